/* sv/dva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice allocator package
// Shared codes, field widths, the result record and the drum note map.
// ----------------------------------------------------------------------------
package dva_pkg;

    // Field widths fixed by the interface.
    localparam int CmdW    = 2;
    localparam int NoteW   = 7;
    localparam int LevelW  = 7;
    localparam int MaskW   = 4;
    localparam int SlotW   = 2;
    localparam int ActW    = 3;
    localparam int SampleW = 4;
    localparam int CoefW   = 16;
    localparam int CountW  = 3;

    // Command codes.
    localparam logic [CmdW-1:0] CmdNoteOn  = 2'd0;
    localparam logic [CmdW-1:0] CmdNoteOff = 2'd1;
    localparam logic [CmdW-1:0] CmdDone    = 2'd2;

    // Action codes reported with each result.
    localparam logic [ActW-1:0] ActNew       = 3'd0;
    localparam logic [ActW-1:0] ActRetrigger = 3'd1;
    localparam logic [ActW-1:0] ActEvict     = 3'd2;
    localparam logic [ActW-1:0] ActRelease   = 3'd3;
    localparam logic [ActW-1:0] ActCompact   = 3'd4;

    // Filter pole base, 0.999 in Q0.16, and the velocity slope 0.6/128 times 4.
    localparam logic [CoefW-1:0] PoleBase  = 16'd65470;
    localparam logic [17:0]      PoleSlope = 18'd1229;

    // Reciprocal of 25 scaled by 2^12 (with the times-128 folded in), exact
    // for all 7-bit levels.
    localparam logic [21:0] RelRecip = 22'd20972;

    // One result item.
    typedef struct packed {
        logic [SlotW-1:0]   slot;
        logic [ActW-1:0]    action;
        logic [SampleW-1:0] sample_index;
        logic [CoefW-1:0]   pole;
        logic [CoefW-1:0]   gain;
        logic [CountW-1:0]  voice_count;
    } dva_result_t;

    // General MIDI percussion notes mapped to the drum sample set.
    function automatic logic [SampleW-1:0] note_sample(input logic [NoteW-1:0] note);
        logic [SampleW-1:0] s;
        case (note)
            7'd36:   s = 4'd1;
            7'd38:   s = 4'd2;
            7'd40:   s = 4'd2;
            7'd41:   s = 4'd3;
            7'd42:   s = 4'd6;
            7'd43:   s = 4'd3;
            7'd44:   s = 4'd6;
            7'd45:   s = 4'd4;
            7'd46:   s = 4'd7;
            7'd47:   s = 4'd4;
            7'd48:   s = 4'd5;
            7'd49:   s = 4'd8;
            7'd50:   s = 4'd5;
            7'd54:   s = 4'd10;
            7'd56:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

/* sv/dva_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice allocator table logic
// Computes the next voice table, voice count and result for one command.
// ----------------------------------------------------------------------------
module dva_table #(
    parameter int VOICES = 4
) (
    input  logic [dva_pkg::CmdW-1:0]                 cmd,
    input  logic [dva_pkg::NoteW-1:0]                note,
    input  logic [dva_pkg::LevelW-1:0]               lvl,
    input  logic [dva_pkg::MaskW-1:0]                mask,
    input  logic [VOICES-1:0][dva_pkg::NoteW-1:0]    notes,
    input  logic [$clog2(VOICES+1)-1:0]              count,
    output logic [VOICES-1:0][dva_pkg::NoteW-1:0]    notes_next,
    output logic [$clog2(VOICES+1)-1:0]              count_next,
    output logic                                     emit,
    output dva_pkg::dva_result_t                     result
);
    import dva_pkg::*;

    localparam int CW = $clog2(VOICES + 1);
    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [17:0]   pole_prod;
    logic [21:0]   rel_prod;
    logic [CW-1:0] kept_n;

    // Velocity-derived pole and release gain.
    assign pole_prod = 18'(lvl) * PoleSlope;
    assign rel_prod  = 22'(lvl) * RelRecip;

    // Highest occupied slot already holding this note.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            if ((CW'(i) < count) && (notes[i] == note))
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // Table update and result formation.
    always_comb
    begin
        notes_next          = notes;
        count_next          = count;
        emit                = 1'b1;
        kept_n              = '0;
        result              = '0;
        case (cmd)
            CmdNoteOn:
            begin
                result.sample_index = note_sample(note);
                result.pole         = PoleBase - pole_prod[17:2];
                result.gain         = {lvl, 9'd0};
                if (hit)
                begin
                    result.slot   = SlotW'(hit_idx);
                    result.action = ActRetrigger;
                end
                else if (count == CW'(VOICES))
                begin
                    // Oldest voice drops out, the rest move down one slot.
                    for (int i = 0; i < VOICES - 1; i++)
                    begin
                        notes_next[i] = notes[i + 1];
                    end
                    notes_next[VOICES-1] = note;
                    result.slot          = SlotW'(VOICES - 1);
                    result.action        = ActEvict;
                end
                else
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        if (CW'(i) == count)
                        begin
                            notes_next[i] = note;
                        end
                    end
                    count_next    = count + CW'(1);
                    result.slot   = SlotW'(count);
                    result.action = ActNew;
                end
            end
            CmdNoteOff:
            begin
                result.action = ActRelease;
                result.gain   = CoefW'(rel_prod[21:12]);
            end
            CmdDone:
            begin
                // Keep unfinished voices in age order; only the first four
                // slots have a mask bit.
                for (int i = 0; i < VOICES; i++)
                begin
                    if ((CW'(i) < count) && !((i < MaskW) && mask[2'(i)]))
                    begin
                        notes_next[kept_n[IW-1:0]] = notes[i];
                        kept_n = kept_n + CW'(1);
                    end
                end
                count_next    = kept_n;
                result.action = ActCompact;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        result.voice_count = CountW'(count_next);
    end

endmodule

/* sv/drum_voice_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice allocator
// Voice table for a polyphonic drum player with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Path: a command passes the input register, then the result register; its
// result is valid on the output once it is held in the result register.
// Throughput: one command per cycle while the output side is ready; the table
// update is a single pass of compare and shift logic between the two registers.
// Reset: clears both valid flags and the voice count; the slot notes are
// not reset since only occupied slots are ever read.
module drum_voice_allocator #(
    parameter int VOICES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dva_pkg::CmdW-1:0]       command,
    input  logic [dva_pkg::NoteW-1:0]      note_number,
    input  logic [dva_pkg::LevelW-1:0]     level,
    input  logic [dva_pkg::MaskW-1:0]      done_mask,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dva_pkg::SlotW-1:0]      slot,
    output logic [dva_pkg::ActW-1:0]       action,
    output logic [dva_pkg::SampleW-1:0]    sample_index,
    output logic [dva_pkg::CoefW-1:0]      pole,
    output logic [dva_pkg::CoefW-1:0]      gain,
    output logic [dva_pkg::CountW-1:0]     voice_count
);
    import dva_pkg::*;

    localparam int CW = $clog2(VOICES + 1);

    // Input stage.
    logic                         stage_valid_reg;
    logic [CmdW-1:0]              cmd_reg;
    logic [NoteW-1:0]             note_reg;
    logic [LevelW-1:0]            level_reg;
    logic [MaskW-1:0]             mask_reg;

    // Voice table.
    logic [VOICES-1:0][NoteW-1:0] notes_reg;
    logic [VOICES-1:0][NoteW-1:0] notes_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;

    // Result stage.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    dva_result_t                  res_reg;
    dva_result_t                  res_next;

    logic                         emit;
    logic                         advance;

    dva_table #(
        .VOICES (VOICES)
    ) u_table (
        .cmd        (cmd_reg),
        .note       (note_reg),
        .lvl        (level_reg),
        .mask       (mask_reg),
        .notes      (notes_reg),
        .count      (count_reg),
        .notes_next (notes_next),
        .count_next (count_next),
        .emit       (emit),
        .result     (res_next)
    );

    // The staged command moves on when the result register can take it;
    // commands without a result never wait.
    assign advance  = stage_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    // Result register holds its item until the output transfer.
    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg   <= command;
            note_reg  <= note_number;
            level_reg <= level;
            mask_reg  <= done_mask;
        end
        if (advance)
        begin
            notes_reg <= notes_next;
        end
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = res_reg.slot;
    assign action       = res_reg.action;
    assign sample_index = res_reg.sample_index;
    assign pole         = res_reg.pole;
    assign gain         = res_reg.gain;
    assign voice_count  = res_reg.voice_count;

    // The voice count never exceeds the number of slots.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(VOICES))
        else $error("voice count above slot count");

    // A processed note-on always leaves at least one voice sounding.
    a_note_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == CmdNoteOn) |=> (count_reg != '0))
        else $error("note-on left the table empty");

    // A steal only happens with the table full.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.action == ActEvict)
            |-> (res_reg.voice_count == CountW'(VOICES)))
        else $error("eviction reported with table not full");

    // A staged command that cannot move on is kept.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> stage_valid_reg)
        else $error("staged command lost");

endmodule
